[rtl/cia_pkg.sv]
`default_nettype none
package cia_pkg;

  localparam int FRAC_BITS     = 8;
  localparam int CORDIC_STAGES = 20;

  // Rounding shift from the product units down to Q16.16
  localparam int QSHIFT = 2 * FRAC_BITS + 14;

  // Angles are unsigned Q2.30
  localparam logic [31:0] ANG_PI      = 32'd3373259426;
  localparam logic [31:0] ANG_HALF_PI = 32'd1686629713;

  // CORDIC datapath widths
  localparam int XW = 40;
  localparam int ZW = 35;
  localparam int AW = 35;

  typedef enum logic [1:0] {
    CASE_INVALID   = 2'd0,
    CASE_SEPARATE  = 2'd1,
    CASE_CONTAINED = 2'd2,
    CASE_PARTIAL   = 2'd3
  } cia_case_t;

  typedef struct packed {
    logic signed [15:0] first_x;
    logic signed [15:0] first_y;
    logic [14:0]        first_radius;
    logic signed [15:0] second_x;
    logic signed [15:0] second_y;
    logic [14:0]        second_radius;
  } cia_circles_t;

  typedef struct packed {
    logic [31:0] overlap_area;
    logic [1:0]  case_code;
  } cia_area_t;

  // Per-item data that rides alongside the root and angle pipelines
  typedef struct packed {
    cia_case_t          kind;
    logic [29:0]        r1sq;
    logic [29:0]        r2sq;
    logic [61:0]        cont_q;
    logic signed [AW-1:0] a1;
    logic signed [AW-1:0] a2;
  } cia_side_t;

  // atan(2^-i) in Q2.30
  function automatic logic [31:0] atan_entry(input int i);
    logic [31:0] val;
    case (i)
      0: val = 32'd843314857;
      1: val = 32'd497837830;
      2: val = 32'd263043837;
      3: val = 32'd133525159;
      4: val = 32'd67021687;
      5: val = 32'd33543516;
      6: val = 32'd16775851;
      7: val = 32'd8388437;
      8: val = 32'd4194283;
      9: val = 32'd2097149;
      default: val = (i <= 30) ? (32'd1 << (30 - i)) : 32'd0;
    endcase
    return val;
  endfunction

endpackage
`default_nettype wire

[rtl/cia_isqrt.sv]
`default_nettype none
module cia_isqrt (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             en,
  input  wire logic             in_vld,
  input  wire logic [63:0]      radicand,
  input  wire cia_pkg::cia_side_t in_side,
  output logic                  out_vld,
  output logic [31:0]           root,
  output cia_pkg::cia_side_t    out_side
);

  localparam int STEPS = 32;

  logic [63:0]        rem  [0:STEPS-1];
  logic [63:0]        res  [0:STEPS-1];
  logic               vld  [0:STEPS-1];
  cia_pkg::cia_side_t side [0:STEPS-1];

  // One digit of the bitwise root recurrence per stage
  for (genvar j = 0; j < STEPS; j++) begin : g_step
    localparam logic [63:0] BIT = 64'd1 << (62 - 2 * j);
    logic [63:0]        rem_in;
    logic [63:0]        res_in;
    logic               vld_in;
    cia_pkg::cia_side_t side_in;
    logic [63:0]        trial;
    logic               take;

    if (j == 0) begin : g_first
      assign rem_in  = radicand;
      assign res_in  = 64'd0;
      assign vld_in  = in_vld;
      assign side_in = in_side;
    end else begin : g_next
      assign rem_in  = rem[j-1];
      assign res_in  = res[j-1];
      assign vld_in  = vld[j-1];
      assign side_in = side[j-1];
    end

    assign trial = res_in + BIT;
    assign take  = rem_in >= trial;

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[j] <= 1'b0;
      end else if (en) begin
        vld[j] <= vld_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem[j]  <= take ? rem_in - trial : rem_in;
        res[j]  <= take ? (res_in >> 1) + BIT : res_in >> 1;
        side[j] <= side_in;
      end
    end
  end

  assign out_vld  = vld[STEPS-1];
  assign root     = res[STEPS-1][31:0];
  assign out_side = side[STEPS-1];

endmodule
`default_nettype wire

[rtl/cia_cordic.sv]
`default_nettype none
module cia_cordic (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             en,
  input  wire logic             in_vld,
  input  wire logic [31:0]      k_in,
  input  wire cia_pkg::cia_side_t in_side,
  output logic                  out_vld,
  output logic [31:0]           k_out,
  output logic [31:0]           t1,
  output logic [31:0]           t2,
  output cia_pkg::cia_side_t    out_side
);

  localparam int XW = cia_pkg::XW;
  localparam int ZW = cia_pkg::ZW;
  localparam int NS = cia_pkg::CORDIC_STAGES + 1;

  logic signed [XW-1:0] x1 [0:NS-1];
  logic signed [XW-1:0] y1 [0:NS-1];
  logic signed [ZW-1:0] z1 [0:NS-1];
  logic signed [XW-1:0] x2 [0:NS-1];
  logic signed [XW-1:0] y2 [0:NS-1];
  logic signed [ZW-1:0] z2 [0:NS-1];
  logic [31:0]          kk [0:NS-1];
  logic                 vld [0:NS-1];
  cia_pkg::cia_side_t   side [0:NS-1];

  for (genvar s = 0; s < NS; s++) begin : g_stage
    logic signed [XW-1:0] x1n, y1n, x2n, y2n;
    logic signed [ZW-1:0] z1n, z2n;
    logic                 vld_in;
    logic [31:0]          k_in_s;
    cia_pkg::cia_side_t   side_in;

    if (s == 0) begin : g_pre
      logic signed [XW-1:0] kx, a1x, a2x;
      // Rotate a negative start vector by -pi/2 (clockwise) so it lands in the right half
      assign kx  = XW'($signed({1'b0, k_in}));
      assign a1x = XW'(in_side.a1);
      assign a2x = XW'(in_side.a2);
      always_comb begin
        if (in_side.a1 < 0) begin
          x1n = kx;
          y1n = -a1x;
          z1n = ZW'(cia_pkg::ANG_HALF_PI);
        end else begin
          x1n = a1x;
          y1n = kx;
          z1n = '0;
        end
        if (in_side.a2 < 0) begin
          x2n = kx;
          y2n = -a2x;
          z2n = ZW'(cia_pkg::ANG_HALF_PI);
        end else begin
          x2n = a2x;
          y2n = kx;
          z2n = '0;
        end
      end
      assign vld_in  = in_vld;
      assign k_in_s  = k_in;
      assign side_in = in_side;
    end else begin : g_iter
      localparam int SH = s - 1;
      localparam logic signed [ZW-1:0] ATN = ZW'(cia_pkg::atan_entry(SH));
      // Drive y toward zero and accumulate the angle in both lanes
      always_comb begin
        if (y1[s-1] >= 0) begin
          x1n = x1[s-1] + (y1[s-1] >>> SH);
          y1n = y1[s-1] - (x1[s-1] >>> SH);
          z1n = z1[s-1] + ATN;
        end else begin
          x1n = x1[s-1] - (y1[s-1] >>> SH);
          y1n = y1[s-1] + (x1[s-1] >>> SH);
          z1n = z1[s-1] - ATN;
        end
        if (y2[s-1] >= 0) begin
          x2n = x2[s-1] + (y2[s-1] >>> SH);
          y2n = y2[s-1] - (x2[s-1] >>> SH);
          z2n = z2[s-1] + ATN;
        end else begin
          x2n = x2[s-1] - (y2[s-1] >>> SH);
          y2n = y2[s-1] + (x2[s-1] >>> SH);
          z2n = z2[s-1] - ATN;
        end
      end
      assign vld_in  = vld[s-1];
      assign k_in_s  = kk[s-1];
      assign side_in = side[s-1];
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[s] <= 1'b0;
      end else if (en) begin
        vld[s] <= vld_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        x1[s]   <= x1n;
        y1[s]   <= y1n;
        z1[s]   <= z1n;
        x2[s]   <= x2n;
        y2[s]   <= y2n;
        z2[s]   <= z2n;
        kk[s]   <= k_in_s;
        side[s] <= side_in;
      end
    end
  end

  // Clamp the final angles to [0, pi]
  function automatic logic [31:0] clamp_ang(input logic signed [ZW-1:0] z);
    logic [31:0] r;
    if (z < 0) begin
      r = 32'd0;
    end else if (z > $signed({3'b0, cia_pkg::ANG_PI})) begin
      r = cia_pkg::ANG_PI;
    end else begin
      r = z[31:0];
    end
    return r;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else if (en) begin
      out_vld <= vld[NS-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      t1       <= clamp_ang(z1[NS-1]);
      t2       <= clamp_ang(z2[NS-1]);
      k_out    <= kk[NS-1];
      out_side <= side[NS-1];
    end
  end

endmodule
`default_nettype wire

[rtl/circle_intersection_area_top.sv]
`default_nettype none
// Overlap area of two circles.
//
// circle channel: one pair of circles per transfer (signed Q7.8 centres,
// unsigned Q7.8 radii). area channel: one result per pair, the overlap area
// in unsigned Q16.16 (saturating) and a case code (invalid radius, separate,
// contained, partial overlap).
//
// The datapath is a fixed pipeline: five setup stages (differences, squares,
// distance, compares, radicand product), 32 root stages (one digit each),
// 22 CORDIC stages (pre-rotation, 20 iterations, clamp) and three stages for
// the segment products, subtraction and rounding. One pair is accepted every
// cycle while the skid register is empty.
//
// Reset clears every valid bit; no results are pending after reset.
// When the receiver stalls, one finished result is caught in a skid register
// and the pipeline freezes only after that, so circle_ready falls in the cycle
// after a stall begins and rises again as soon as the skid result is taken.
module circle_intersection_area_top (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   circle_valid,
  output logic                        circle_ready,
  input  wire cia_pkg::cia_circles_t  circle,
  output logic                        area_valid,
  input  wire logic                   area_ready,
  output cia_pkg::cia_area_t          area
);

  logic en;

  // Stage 1: differences and radius sums
  logic                s1_vld, s1_bad;
  logic signed [16:0]  s1_dx, s1_dy;
  logic [14:0]         s1_r1, s1_r2, s1_dif, s1_rmin;
  logic [15:0]         s1_sum;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_vld <= 1'b0;
    end else if (en) begin
      s1_vld <= circle_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_dx   <= {circle.first_x[15], circle.first_x} - {circle.second_x[15], circle.second_x};
      s1_dy   <= {circle.first_y[15], circle.first_y} - {circle.second_y[15], circle.second_y};
      s1_r1   <= circle.first_radius;
      s1_r2   <= circle.second_radius;
      s1_sum  <= {1'b0, circle.first_radius} + {1'b0, circle.second_radius};
      s1_dif  <= (circle.first_radius > circle.second_radius) ?
                 circle.first_radius - circle.second_radius :
                 circle.second_radius - circle.first_radius;
      s1_rmin <= (circle.first_radius < circle.second_radius) ?
                 circle.first_radius : circle.second_radius;
      s1_bad  <= (circle.first_radius == 15'd0) || (circle.second_radius == 15'd0);
    end
  end

  // Stage 2: squares
  logic               s2_vld, s2_bad;
  logic [31:0]        s2_dx2, s2_dy2, s2_sum2;
  logic [29:0]        s2_dif2, s2_r1sq, s2_r2sq, s2_rmin2;
  logic signed [33:0] pdx, pdy;

  assign pdx = s1_dx * s1_dx;
  assign pdy = s1_dy * s1_dy;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_vld <= 1'b0;
    end else if (en) begin
      s2_vld <= s1_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_dx2   <= pdx[31:0];
      s2_dy2   <= pdy[31:0];
      s2_sum2  <= s1_sum * s1_sum;
      s2_dif2  <= s1_dif * s1_dif;
      s2_r1sq  <= s1_r1 * s1_r1;
      s2_r2sq  <= s1_r2 * s1_r2;
      s2_rmin2 <= s1_rmin * s1_rmin;
      s2_bad   <= s1_bad;
    end
  end

  // Stage 3: squared distance and the contained area product
  logic        s3_vld, s3_bad;
  logic [32:0] s3_d2;
  logic [31:0] s3_sum2;
  logic [29:0] s3_dif2, s3_r1sq, s3_r2sq;
  logic [61:0] s3_cont_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_vld <= 1'b0;
    end else if (en) begin
      s3_vld <= s2_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s3_d2     <= {1'b0, s2_dx2} + {1'b0, s2_dy2};
      s3_cont_q <= 62'(s2_rmin2) * 62'(cia_pkg::ANG_PI);
      s3_sum2   <= s2_sum2;
      s3_dif2   <= s2_dif2;
      s3_r1sq   <= s2_r1sq;
      s3_r2sq   <= s2_r2sq;
      s3_bad    <= s2_bad;
    end
  end

  // Stage 4: classify, radicand factors, CORDIC start values
  logic               s4_vld;
  logic [31:0]        s4_u, s4_v;
  cia_pkg::cia_side_t s4_side, s4_side_next;
  logic signed [35:0] a1w, a2w;

  assign a1w = $signed({3'b0, s3_d2}) + $signed({6'b0, s3_r1sq}) - $signed({6'b0, s3_r2sq});
  assign a2w = $signed({3'b0, s3_d2}) + $signed({6'b0, s3_r2sq}) - $signed({6'b0, s3_r1sq});

  always_comb begin
    s4_side_next.r1sq   = s3_r1sq;
    s4_side_next.r2sq   = s3_r2sq;
    s4_side_next.cont_q = s3_cont_q;
    s4_side_next.a1     = a1w[cia_pkg::AW-1:0];
    s4_side_next.a2     = a2w[cia_pkg::AW-1:0];
    if (s3_bad) begin
      s4_side_next.kind = cia_pkg::CASE_INVALID;
    end else if (s3_d2 >= {1'b0, s3_sum2}) begin
      s4_side_next.kind = cia_pkg::CASE_SEPARATE;
    end else if (s3_d2 <= {3'b0, s3_dif2}) begin
      s4_side_next.kind = cia_pkg::CASE_CONTAINED;
    end else begin
      s4_side_next.kind = cia_pkg::CASE_PARTIAL;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s4_vld <= 1'b0;
    end else if (en) begin
      s4_vld <= s3_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s4_u    <= 32'({1'b0, s3_sum2} - s3_d2);
      s4_v    <= 32'(s3_d2 - {3'b0, s3_dif2});
      s4_side <= s4_side_next;
    end
  end

  // Stage 5: radicand
  logic               s5_vld;
  logic [63:0]        s5_p;
  cia_pkg::cia_side_t s5_side;

  always_ff @(posedge clk) begin
    if (rst) begin
      s5_vld <= 1'b0;
    end else if (en) begin
      s5_vld <= s4_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s5_p    <= 64'(s4_u) * 64'(s4_v);
      s5_side <= s4_side;
    end
  end

  // Root and angle pipelines
  logic               sq_vld;
  logic [31:0]        sq_k;
  cia_pkg::cia_side_t sq_side;

  cia_isqrt u_isqrt (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_vld   (s5_vld),
    .radicand (s5_p),
    .in_side  (s5_side),
    .out_vld  (sq_vld),
    .root     (sq_k),
    .out_side (sq_side)
  );

  logic               co_vld;
  logic [31:0]        co_k, co_t1, co_t2;
  cia_pkg::cia_side_t co_side;

  cia_cordic u_cordic (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_vld   (sq_vld),
    .k_in     (sq_k),
    .in_side  (sq_side),
    .out_vld  (co_vld),
    .k_out    (co_k),
    .t1       (co_t1),
    .t2       (co_t2),
    .out_side (co_side)
  );

  // Stage M: segment products
  logic        m_vld;
  logic [61:0] m_p1, m_p2;
  logic [31:0] m_k;
  cia_pkg::cia_case_t m_kind;
  logic [61:0] m_cont_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_vld <= 1'b0;
    end else if (en) begin
      m_vld <= co_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_p1     <= 62'(co_side.r1sq) * 62'(co_t1);
      m_p2     <= 62'(co_side.r2sq) * 62'(co_t2);
      m_k      <= co_k;
      m_kind   <= co_side.kind;
      m_cont_q <= co_side.cont_q;
    end
  end

  // Stage N: sum of segments minus the triangle term, clamped at zero
  logic               n_vld;
  logic [62:0]        n_area;
  cia_pkg::cia_case_t n_kind;
  logic [61:0]        n_cont_q;
  logic [62:0]        pos, neg;

  assign pos = {1'b0, m_p1} + {1'b0, m_p2};
  assign neg = {2'b0, m_k, 29'b0};

  always_ff @(posedge clk) begin
    if (rst) begin
      n_vld <= 1'b0;
    end else if (en) begin
      n_vld <= m_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      n_area   <= (pos > neg) ? pos - neg : 63'd0;
      n_kind   <= m_kind;
      n_cont_q <= m_cont_q;
    end
  end

  // Stage F: select by case, round half up to Q16.16, saturate
  logic               f_vld;
  cia_pkg::cia_area_t f_data, f_data_next;
  logic [63:0]        q, rq;

  always_comb begin
    case (n_kind)
      cia_pkg::CASE_CONTAINED: q = {2'b0, n_cont_q};
      cia_pkg::CASE_PARTIAL:   q = {1'b0, n_area};
      default:                 q = 64'd0;
    endcase
    rq = ((q >> 1) + (64'd1 << (cia_pkg::QSHIFT - 2))) >> (cia_pkg::QSHIFT - 1);
    f_data_next.overlap_area = (rq > 64'h0000_0000_FFFF_FFFF) ? 32'hFFFF_FFFF : rq[31:0];
    f_data_next.case_code    = n_kind;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      f_vld <= 1'b0;
    end else if (en) begin
      f_vld <= n_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      f_data <= f_data_next;
    end
  end

  // Skid register: catch one result when the receiver stalls
  logic               skid_vld;
  cia_pkg::cia_area_t skid_data;

  assign en = !skid_vld;

  always_ff @(posedge clk) begin
    if (rst) begin
      skid_vld <= 1'b0;
    end else if (skid_vld) begin
      if (area_ready) begin
        skid_vld <= 1'b0;
      end
    end else if (f_vld && !area_ready) begin
      skid_vld <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!skid_vld && f_vld && !area_ready) begin
      skid_data <= f_data;
    end
  end

  assign circle_ready = en;
  assign area_valid   = skid_vld || f_vld;
  assign area         = skid_vld ? skid_data : f_data;

  // Invalid and separate pairs report no area
  a_zero_area: assert property (@(posedge clk) disable iff (rst)
    area_valid && (area.case_code == cia_pkg::CASE_INVALID ||
                   area.case_code == cia_pkg::CASE_SEPARATE)
    |-> area.overlap_area == 32'd0)
    else $error("nonzero area for invalid or separate pair");

  // A contained circle has a radius of at least one LSB, so its area is nonzero
  a_cont_area: assert property (@(posedge clk) disable iff (rst)
    area_valid && area.case_code == cia_pkg::CASE_CONTAINED
    |-> area.overlap_area != 32'd0)
    else $error("zero area for contained pair");

  // A held skid result stays until the receiver takes it
  a_skid_hold: assert property (@(posedge clk) disable iff (rst)
    skid_vld && !area_ready |=> skid_vld && $stable(skid_data))
    else $error("skid result lost during stall");

  // The pipeline stays frozen while the skid register is full
  a_freeze: assert property (@(posedge clk) disable iff (rst)
    skid_vld |=> $stable(f_data) && $stable(f_vld))
    else $error("pipeline advanced while skid full");

endmodule
`default_nettype wire
